// ===== rtl/core/atpll_pkg.sv =====
// Shared types, fixed-point constants and the microcode ROM of the angle-tracking PLL.
// Used by atpll_regs, atpll_seq, atpll_dp and angle_tracking_pll_top; no dependencies.
`default_nettype none

package atpll_pkg;

    localparam int unsigned STEP_W  = 4;
    localparam int unsigned MUL_A_W = 34;
    localparam int unsigned MUL_B_W = 20;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
    localparam int unsigned PADDR_W = 4;

    typedef logic [STEP_W-1:0] t_step;

    // Q16.16 constants: pi, 2*pi, and the reciprocals used for the two divisions by 2*pi.
    localparam logic signed [MUL_B_W-1:0] K_PI       = 20'sd205887;
    localparam logic signed [MUL_B_W-1:0] K_TWO_PI   = 20'sd411775;
    localparam logic signed [MUL_B_W-1:0] K_RCP_TURN = 20'sd41721;   // floor(2^34 / 2pi)
    localparam logic signed [MUL_B_W-1:0] K_RCP_ANG  = 20'sd166885;  // floor(2^36 / 2pi)
    localparam logic [20:0]               K_TWO_PI_U = 21'd411775;
    // Multiple of 2*pi that lifts any phase sum above zero before the modulo.
    localparam logic signed [34:0]        K_TURN_BIAS = 35'sd2147818400;

    localparam logic [30:0] RST_PROP_GAIN     = 31'd0;
    localparam logic [30:0] RST_INTEG_GAIN    = 31'd0;
    localparam logic [30:0] RST_SPEED_LIMIT   = 31'd205887416;
    localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd3;

    typedef enum logic [1:0] {
        REG_PROP_GAIN     = 2'd0,
        REG_INTEG_GAIN    = 2'd1,
        REG_SPEED_LIMIT   = 2'd2,
        REG_SAMPLE_PERIOD = 2'd3
    } t_reg;

    typedef struct packed {
        logic [30:0] prop_gain;
        logic [30:0] integ_gain;
        logic [30:0] speed_limit;
        logic [15:0] sample_period;
    } t_cfg;

    typedef enum logic [2:0] {
        A_NONE  = 3'd0,
        A_MEAS  = 3'd1,
        A_IGAIN = 3'd2,
        A_PGAIN = 3'd3,
        A_SPEED = 3'd4,
        A_SUM   = 3'd5,
        A_QUO   = 3'd6,
        A_PHASE = 3'd7
    } t_asel;

    typedef enum logic [2:0] {
        B_TWO_PI   = 3'd0,
        B_ERR      = 3'd1,
        B_PERIOD   = 3'd2,
        B_RCP_TURN = 3'd3,
        B_RCP_ANG  = 3'd4
    } t_bsel;

    typedef enum logic [3:0] {
        AL_NOP   = 4'd0,
        AL_LOAD  = 4'd1,
        AL_ERR   = 4'd2,
        AL_INTEG = 4'd3,
        AL_SPEED = 4'd4,
        AL_SUM   = 4'd5,
        AL_QUO   = 4'd6,
        AL_WRAP  = 4'd7,
        AL_QANG  = 4'd8,
        AL_OUT   = 4'd9
    } t_alu;

    typedef enum logic [1:0] {
        SQ_NEXT = 2'd0,
        SQ_IN   = 2'd1,
        SQ_OUT  = 2'd2
    } t_seq;

    localparam t_step STEP_IDLE = 4'd0;

    typedef struct packed {
        t_asel a_sel;
        t_bsel b_sel;
        logic  mul_en;
        t_alu  alu;
        t_seq  seq;
        t_step target;
    } t_uword;

    typedef struct packed {
        t_asel a_sel;
        t_bsel b_sel;
        logic  mul_en;
        t_alu  alu;
        logic  alu_en;
    } t_dp_ctrl;

    function automatic t_uword uw(input t_asel a, input t_bsel b, input logic m,
                                  input t_alu al, input t_seq s);
        t_uword w;
        w.a_sel  = a;
        w.b_sel  = b;
        w.mul_en = m;
        w.alu    = al;
        w.seq    = s;
        w.target = STEP_IDLE;
        return w;
    endfunction

    // One control word per step. A product issued in one step is consumed by the ALU
    // in the next step.
    function automatic t_uword ucode(input t_step pc);
        t_uword w;
        case (pc)
            4'd0:    w = uw(A_NONE,  B_TWO_PI,   1'b0, AL_LOAD,  SQ_IN);
            4'd1:    w = uw(A_MEAS,  B_TWO_PI,   1'b1, AL_NOP,   SQ_NEXT);
            4'd2:    w = uw(A_NONE,  B_TWO_PI,   1'b0, AL_ERR,   SQ_NEXT);
            4'd3:    w = uw(A_IGAIN, B_ERR,      1'b1, AL_NOP,   SQ_NEXT);
            4'd4:    w = uw(A_PGAIN, B_ERR,      1'b1, AL_INTEG, SQ_NEXT);
            4'd5:    w = uw(A_NONE,  B_TWO_PI,   1'b0, AL_SPEED, SQ_NEXT);
            4'd6:    w = uw(A_SPEED, B_PERIOD,   1'b1, AL_NOP,   SQ_NEXT);
            4'd7:    w = uw(A_NONE,  B_TWO_PI,   1'b0, AL_SUM,   SQ_NEXT);
            4'd8:    w = uw(A_SUM,   B_RCP_TURN, 1'b1, AL_NOP,   SQ_NEXT);
            4'd9:    w = uw(A_NONE,  B_TWO_PI,   1'b0, AL_QUO,   SQ_NEXT);
            4'd10:   w = uw(A_QUO,   B_TWO_PI,   1'b1, AL_NOP,   SQ_NEXT);
            4'd11:   w = uw(A_NONE,  B_TWO_PI,   1'b0, AL_WRAP,  SQ_NEXT);
            4'd12:   w = uw(A_PHASE, B_RCP_ANG,  1'b1, AL_NOP,   SQ_NEXT);
            4'd13:   w = uw(A_NONE,  B_TWO_PI,   1'b0, AL_QANG,  SQ_NEXT);
            4'd14:   w = uw(A_QUO,   B_TWO_PI,   1'b1, AL_NOP,   SQ_NEXT);
            4'd15:   w = uw(A_NONE,  B_TWO_PI,   1'b0, AL_OUT,   SQ_OUT);
            default: w = uw(A_NONE,  B_TWO_PI,   1'b0, AL_NOP,   SQ_OUT);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/atpll_regs.sv =====
// APB register file holding the loop gains, the speed limit and the sample period.
// Depends on atpll_pkg for the register map, reset values and the t_cfg bundle.
`default_nettype none

module atpll_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [atpll_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output atpll_pkg::t_cfg                   o_cfg
);
    import atpll_pkg::*;

    t_cfg r_cfg;
    t_reg reg_idx;
    logic wr_en;

    assign reg_idx = t_reg'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain     <= RST_PROP_GAIN;
            r_cfg.integ_gain    <= RST_INTEG_GAIN;
            r_cfg.speed_limit   <= RST_SPEED_LIMIT;
            r_cfg.sample_period <= RST_SAMPLE_PERIOD;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PROP_GAIN:     r_cfg.prop_gain     <= pwdata[30:0];
                REG_INTEG_GAIN:    r_cfg.integ_gain    <= pwdata[30:0];
                REG_SPEED_LIMIT:   r_cfg.speed_limit   <= pwdata[30:0];
                REG_SAMPLE_PERIOD: r_cfg.sample_period <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PROP_GAIN:     prdata = {1'b0, r_cfg.prop_gain};
            REG_INTEG_GAIN:    prdata = {1'b0, r_cfg.integ_gain};
            REG_SPEED_LIMIT:   prdata = {1'b0, r_cfg.speed_limit};
            REG_SAMPLE_PERIOD: prdata = {16'd0, r_cfg.sample_period};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/atpll_seq.sv =====
// Microcode sequencer: step counter, control ROM fetch and the two conditional jumps
// (wait for an input beat, wait for a free output slot). Depends on atpll_pkg.
`default_nettype none

module atpll_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_out_busy,
    output logic                o_in_ready,
    output atpll_pkg::t_dp_ctrl o_ctrl
);
    import atpll_pkg::*;

    t_step  r_pc;
    t_step  n_pc;
    t_uword word;
    logic   step_go;

    assign word       = ucode(r_pc);
    assign o_in_ready = (word.seq == SQ_IN);

    always_comb begin
        unique case (word.seq)
            SQ_IN:   step_go = i_in_valid;
            SQ_OUT:  step_go = !i_out_busy;
            default: step_go = 1'b1;
        endcase
    end

    always_comb begin
        n_pc = r_pc;
        if (step_go) begin
            if (word.seq == SQ_OUT) begin
                n_pc = word.target;
            end else begin
                n_pc = r_pc + t_step'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.a_sel  = word.a_sel;
    assign o_ctrl.b_sel  = word.b_sel;
    assign o_ctrl.mul_en = word.mul_en;
    assign o_ctrl.alu    = word.alu;
    assign o_ctrl.alu_en = step_go;

endmodule

`default_nettype wire

// ===== rtl/core/atpll_dp.sv =====
// Datapath of the tracking loop: one registered 34x20 signed multiplier, a small ALU,
// the loop state and the output register. Depends on atpll_pkg.
`default_nettype none

module atpll_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire atpll_pkg::t_dp_ctrl i_ctrl,
    input  wire atpll_pkg::t_cfg     i_cfg,
    input  wire logic [15:0]         i_meas,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic                     o_out_busy,
    output logic [15:0]              o_angle,
    output logic signed [31:0]       o_speed
);
    import atpll_pkg::*;

    logic        [15:0]         r_meas;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [19:0]         r_err;
    logic signed [31:0]         r_integ;
    logic signed [31:0]         r_speed;
    logic        [32:0]         r_u;
    logic        [18:0]         r_phase;
    logic        [15:0]         r_q;
    logic                       r_out_valid;
    logic        [15:0]         r_angle;
    logic signed [31:0]         r_out_speed;

    logic signed [MUL_A_W-1:0]  a_op;
    logic signed [MUL_B_W-1:0]  b_op;
    logic signed [PROD_W-1:0]   mul_res;

    logic signed [19:0]         diff;
    logic signed [19:0]         err_wrapped;
    logic signed [37:0]         prod_q16;
    logic signed [38:0]         pi_sum;
    logic signed [31:0]         pi_clamped;
    logic signed [33:0]         step_term;
    logic signed [34:0]         u_sum;
    logic        [20:0]         wrap_rem;
    logic        [18:0]         phase_wrapped;
    logic        [20:0]         ang_rem;
    logic        [15:0]         angle_fixed;
    logic                       out_load;

    function automatic logic signed [31:0] clamp_lim(input logic signed [38:0] v,
                                                     input logic [30:0] lim);
        logic signed [38:0] hi;
        logic signed [38:0] lo;
        hi = $signed({8'd0, lim});
        lo = -hi;
        if (v > hi) begin
            return hi[31:0];
        end else if (v < lo) begin
            return lo[31:0];
        end
        return v[31:0];
    endfunction

    // Operand selection for the shared multiplier.
    always_comb begin
        case (i_ctrl.a_sel)
            A_MEAS:  a_op = $signed({18'd0, r_meas});
            A_IGAIN: a_op = $signed({3'd0, i_cfg.integ_gain});
            A_PGAIN: a_op = $signed({3'd0, i_cfg.prop_gain});
            A_SPEED: a_op = $signed({{2{r_speed[31]}}, r_speed});
            A_SUM:   a_op = $signed({1'b0, r_u});
            A_QUO:   a_op = $signed({18'd0, r_q});
            A_PHASE: a_op = $signed({15'd0, r_phase});
            default: a_op = '0;
        endcase
        case (i_ctrl.b_sel)
            B_ERR:      b_op = r_err;
            B_PERIOD:   b_op = $signed({4'd0, i_cfg.sample_period});
            B_RCP_TURN: b_op = K_RCP_TURN;
            B_RCP_ANG:  b_op = K_RCP_ANG;
            default:    b_op = K_TWO_PI;
        endcase
    end

    assign mul_res = a_op * b_op;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= mul_res;
        end
    end

    // Phase error, wrapped once into plus or minus pi.
    always_comb begin
        diff = $signed({1'b0, r_prod[34:16]}) - $signed({1'b0, r_phase});
        if (diff > K_PI) begin
            err_wrapped = diff - K_TWO_PI;
        end else if (diff < -K_PI) begin
            err_wrapped = diff + K_TWO_PI;
        end else begin
            err_wrapped = diff;
        end
    end

    // Products are floored by the arithmetic shift; integral and speed share the clamp.
    assign prod_q16   = r_prod[53:16];
    assign pi_sum     = $signed({prod_q16[37], prod_q16}) + $signed({{7{r_integ[31]}}, r_integ});
    assign pi_clamped = clamp_lim(pi_sum, i_cfg.speed_limit);

    // The bias keeps the phase sum positive, so the modulo is a plain unsigned remainder.
    assign step_term = r_prod[49:16];
    assign u_sum     = $signed({16'd0, r_phase}) + $signed({step_term[33], step_term})
                     + K_TURN_BIAS;

    // The quotient estimate is exact or one low; the remainder fits in 21 bits.
    assign wrap_rem      = r_u[20:0] - r_prod[20:0];
    assign phase_wrapped = (wrap_rem >= K_TWO_PI_U) ? 19'(wrap_rem - K_TWO_PI_U)
                                                    : wrap_rem[18:0];

    assign ang_rem     = {r_phase[4:0], 16'd0} - r_prod[20:0];
    assign angle_fixed = (ang_rem >= K_TWO_PI_U) ? r_q + 16'd1 : r_q;

    assign out_load = i_ctrl.alu_en && (i_ctrl.alu == AL_OUT);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.alu_en) begin
            case (i_ctrl.alu)
                AL_LOAD:  r_meas  <= i_meas;
                AL_ERR:   r_err   <= err_wrapped;
                AL_SPEED: r_speed <= pi_clamped;
                AL_SUM:   r_u     <= u_sum[32:0];
                AL_QUO:   r_q     <= r_prod[49:34];
                AL_QANG:  r_q     <= r_prod[35:20];
                default: ;
            endcase
        end
        if (out_load) begin
            r_angle     <= angle_fixed;
            r_out_speed <= r_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ     <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.alu_en && (i_ctrl.alu == AL_INTEG)) begin
                r_integ <= pi_clamped;
            end
            if (i_ctrl.alu_en && (i_ctrl.alu == AL_WRAP)) begin
                r_phase <= phase_wrapped;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_busy  = r_out_valid && !i_out_ready;
    assign o_angle     = r_angle;
    assign o_speed     = r_out_speed;

endmodule

`default_nettype wire

// ===== rtl/core/angle_tracking_pll_top.sv =====
// Top level of the type-2 angle-tracking PLL: APB registers, microcode sequencer, datapath.
// Depends on atpll_pkg, atpll_regs, atpll_seq and atpll_dp.
//
//   Port group   Dir  Beat content
//   s_axis_*     in   measured angle, 16-bit turn fraction
//   m_axis_*     out  tracked angle (16-bit turn fraction), tracked speed (Q16.16 rad/s)
//   APB          in   prop_gain @0x0, integ_gain @0x4, speed_limit @0x8, sample_period @0xC
//
// A beat is accepted in step 0 of the 16-step microprogram; the result is loaded into
// the output register in step 15; a new beat is taken only back in step 0. The single
// shared 34x20 multiplier issues in eight of the steps and each product is consumed in
// the next step, so the chain of dependent products sets the length of the program.
// Reset clears the integral and the tracked phase and loads the register defaults.
// While the previous result has not been taken, the program holds in its last step.
`default_nettype none

module angle_tracking_pll_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [15:0]                   s_axis_tdata,   // [15:0] measured_angle
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [47:0]                   m_axis_tdata,   // [15:0] tracked_angle,
                                                               // [47:16] tracked_speed
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [atpll_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);
    import atpll_pkg::*;

    t_cfg               cfg;
    t_dp_ctrl           ctrl;
    logic               out_busy;
    logic [15:0]        angle;
    logic signed [31:0] speed;

    atpll_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    atpll_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_busy (out_busy),
        .o_in_ready (s_axis_tready),
        .o_ctrl     (ctrl)
    );

    atpll_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_cfg       (cfg),
        .i_meas      (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_busy  (out_busy),
        .o_angle     (angle),
        .o_speed     (speed)
    );

    assign m_axis_tdata = {speed, angle};

endmodule

`default_nettype wire
